/* hw/rtl/swcu_pkg.sv */
// ----------------------------------------------------------------------------
// swcu_pkg
// Types and constants shared by the centroid update controller and datapath.
// ----------------------------------------------------------------------------
package swcu_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned SENS_W  = 20;
    localparam int unsigned SUM_W   = 27;
    localparam int unsigned CNT_W   = 11;
    localparam int unsigned GAIN_W  = 10;
    localparam int unsigned CCNT_W  = 5;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned SQ_W    = 34;
    localparam int unsigned RT_W    = 17;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_POINT = 1'b1;

    localparam logic REG_CLUSTER_COUNT    = 1'b0;
    localparam logic REG_SENSITIVITY_GAIN = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCORE_START,
        ST_SQRT,
        ST_COMPARE,
        ST_SENS,
        ST_ACCUM,
        ST_DIV,
        ST_DONE,
        ST_OUT
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic capture;
        logic load;
        logic score_start;
        logic sqrt_step;
        logic compare;
        logic sens_step;
        logic accum;
        logic div_start;
        logic div_step;
        logic finish;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic is_point;
        logic sqrt_done;
        logic last_slot;
        logic div_done;
    } t_status;

endpackage

/* hw/rtl/swcu_ctrl.sv */
// ----------------------------------------------------------------------------
// swcu_ctrl
// Sequencer for load and point items of the centroid update block.
// ----------------------------------------------------------------------------
module swcu_ctrl
    import swcu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = i_status.is_point ? ST_SCORE_START : ST_OUT;
            end
            ST_SCORE_START: n_state = ST_SQRT;
            ST_SQRT: begin
                if (i_status.sqrt_done) begin
                    n_state = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                n_state = i_status.last_slot ? ST_SENS : ST_SCORE_START;
            end
            ST_SENS: begin
                if (i_status.last_slot) begin
                    n_state = ST_ACCUM;
                end
            end
            ST_ACCUM: n_state = ST_DIV;
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: n_state = ST_OUT;
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_LOAD:        o_cmd.load        = 1'b1;
            ST_SCORE_START: o_cmd.score_start = 1'b1;
            ST_SQRT:        o_cmd.sqrt_step   = 1'b1;
            ST_COMPARE:     o_cmd.compare     = 1'b1;
            ST_SENS:        o_cmd.sens_step   = 1'b1;
            ST_ACCUM: begin
                o_cmd.accum     = 1'b1;
                o_cmd.div_start = 1'b1;
            end
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_DONE: o_cmd.finish   = 1'b1;
            ST_OUT:  o_out_valid    = 1'b1;
            default: o_cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_in_ready)
        else $error("input accepted while busy");
    a_out_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD && !i_status.is_point) |=> o_out_valid)
        else $error("load result not presented");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped while stalled");
`endif

endmodule

/* hw/rtl/swcu_dp.sv */
// ----------------------------------------------------------------------------
// swcu_dp
// Datapath: centroid state, iterative square root, scoring and mean divider.
// ----------------------------------------------------------------------------
module swcu_dp
    import swcu_pkg::*;
#(
    parameter int unsigned MAX_CENTROIDS = 16,
    parameter int unsigned MAX_POINTS    = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_status                   o_status,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [GAIN_W-1:0]         i_cfg_data,
    input  logic                      i_operation,
    input  logic [SLOT_W-1:0]         i_centroid_index,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    output logic [SLOT_W-1:0]         o_winner_index,
    output logic signed [COORD_W-1:0] o_center_x,
    output logic signed [COORD_W-1:0] o_center_y,
    output logic [CNT_W-1:0]          o_member_count
);

    localparam int unsigned IDX_W = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
    localparam int unsigned NC_W  = $clog2(MAX_CENTROIDS + 1);
    localparam int unsigned CAP   = (MAX_POINTS < 2047) ? MAX_POINTS : 2047;
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP);
    localparam logic [SENS_W-1:0] SENS_MAX = '1;
    localparam int unsigned DIV_STEPS = SUM_W;
    localparam int unsigned DS_W  = $clog2(DIV_STEPS + 1);
    localparam int unsigned SQ_STEPS = SQ_W / 2;
    localparam int unsigned SS_W  = $clog2(SQ_STEPS + 1);

    // Configuration.
    logic [CCNT_W-1:0] r_cluster_count;
    logic [GAIN_W-1:0] r_gain;

    // Centroid state in flip-flops.
    logic signed [COORD_W-1:0] r_cx   [MAX_CENTROIDS];
    logic signed [COORD_W-1:0] r_cy   [MAX_CENTROIDS];
    logic [SENS_W-1:0]         r_sens [MAX_CENTROIDS];
    logic signed [SUM_W-1:0]   r_sx   [MAX_CENTROIDS];
    logic signed [SUM_W-1:0]   r_sy   [MAX_CENTROIDS];
    logic [CNT_W-1:0]          r_cnt  [MAX_CENTROIDS];

    // Captured item.
    logic                      r_op;
    logic [SLOT_W-1:0]         r_slot;
    logic signed [COORD_W-1:0] r_px, r_py;

    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_win;
    logic signed [SENS_W+1:0] r_best;
    logic [NC_W-1:0]   r_n;

    // Square root unit.
    logic [RT_W-1:0]   r_root;
    logic [SS_W-1:0]   r_sq_cnt;
    logic signed [COORD_W:0] r_dx, r_dy;

    // Divider.
    logic [SUM_W-1:0]  r_qx, r_qy;
    logic [SUM_W:0]    r_rx, r_ry;
    logic              r_negx, r_negy;
    logic [CNT_W-1:0]  r_div_cnt;
    logic [DS_W-1:0]   r_div_step;
    logic              r_upd;

    logic [SLOT_W-1:0]         r_out_idx;
    logic signed [COORD_W-1:0] r_out_x, r_out_y;
    logic [CNT_W-1:0]          r_out_cnt;

    // Derived signals.
    logic [NC_W-1:0]           n_eff;
    logic signed [SENS_W+1:0]  score;
    logic [SQ_W-1:0]           sq;
    logic [CNT_W:0]            cnt_next;
    logic signed [SUM_W-1:0]   sx_new, sy_new;
    logic [SUM_W-1:0]          ax, ay;
    logic [SUM_W:0]            rx_t, ry_t;
    logic [SENS_W:0]           sens_sum;
    logic signed [SUM_W:0]     qx_s, qy_s;

    always_comb begin
        if (r_cluster_count == '0) begin
            n_eff = NC_W'(1);
        end else if (32'(r_cluster_count) > MAX_CENTROIDS) begin
            n_eff = NC_W'(MAX_CENTROIDS);
        end else begin
            n_eff = NC_W'(r_cluster_count);
        end
    end

    assign sq = SQ_W'(r_dx * r_dx) + SQ_W'(r_dy * r_dy);
    assign score = $signed({{(SENS_W+2-RT_W){1'b0}}, r_root}) -
                   $signed({2'b0, r_sens[r_idx]});
    assign cnt_next = {1'b0, r_cnt[r_win]} + 1'b1;
    assign sx_new = r_sx[r_win] + SUM_W'(r_px);
    assign sy_new = r_sy[r_win] + SUM_W'(r_py);
    assign ax = sx_new[SUM_W-1] ? SUM_W'(-sx_new) : SUM_W'(sx_new);
    assign ay = sy_new[SUM_W-1] ? SUM_W'(-sy_new) : SUM_W'(sy_new);
    assign rx_t = {r_rx[SUM_W-1:0], r_qx[SUM_W-1]};
    assign ry_t = {r_ry[SUM_W-1:0], r_qy[SUM_W-1]};
    assign sens_sum = {1'b0, r_sens[r_idx]} + (SENS_W+1)'(r_gain);
    assign qx_s = r_negx ? -$signed({1'b0, r_qx}) : $signed({1'b0, r_qx});
    assign qy_s = r_negy ? -$signed({1'b0, r_qy}) : $signed({1'b0, r_qy});

    assign o_status.is_point  = r_op;
    assign o_status.sqrt_done = (r_sq_cnt == SS_W'(SQ_STEPS));
    assign o_status.last_slot = (NC_W'(r_idx) == NC_W'(r_n - 1'b1));
    assign o_status.div_done  = !r_upd || (r_div_step == DS_W'(DIV_STEPS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_count <= CCNT_W'(1);
            r_gain          <= GAIN_W'(16);
            for (int i = 0; i < MAX_CENTROIDS; i++) begin
                r_cx[i]   <= '0;
                r_cy[i]   <= '0;
                r_sens[i] <= '0;
                r_sx[i]   <= '0;
                r_sy[i]   <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_CLUSTER_COUNT) begin
                    r_cluster_count <= i_cfg_data[CCNT_W-1:0];
                end else begin
                    r_gain <= i_cfg_data;
                end
            end
            if (i_cmd.load && r_op == OP_LOAD && 32'(r_slot) < MAX_CENTROIDS) begin
                r_cx[IDX_W'(r_slot)]   <= r_px;
                r_cy[IDX_W'(r_slot)]   <= r_py;
                r_sens[IDX_W'(r_slot)] <= '0;
                r_sx[IDX_W'(r_slot)]   <= '0;
                r_sy[IDX_W'(r_slot)]   <= '0;
                r_cnt[IDX_W'(r_slot)]  <= '0;
            end
            if (i_cmd.sens_step) begin
                if (r_idx == r_win) begin
                    r_sens[r_idx] <= '0;
                end else if (sens_sum[SENS_W]) begin
                    r_sens[r_idx] <= SENS_MAX;
                end else begin
                    r_sens[r_idx] <= sens_sum[SENS_W-1:0];
                end
            end
            if (i_cmd.accum && r_cnt[r_win] < COUNT_CAP) begin
                r_sx[r_win]  <= sx_new;
                r_sy[r_win]  <= sy_new;
                r_cnt[r_win] <= cnt_next[CNT_W-1:0];
            end
            if (i_cmd.finish && r_upd) begin
                r_cx[r_win] <= COORD_W'(qx_s);
                r_cy[r_win] <= COORD_W'(qy_s);
            end
        end
    end

    // Work registers need no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_operation;
            r_slot <= i_centroid_index;
            r_px   <= i_coord_x;
            r_py   <= i_coord_y;
        end
        if (i_cmd.load) begin
            r_idx <= '0;
            r_win <= '0;
            r_n   <= n_eff;
            r_out_idx <= r_slot;
            r_out_cnt <= '0;
            if (32'(r_slot) < MAX_CENTROIDS) begin
                r_out_x <= r_px;
                r_out_y <= r_py;
            end else begin
                r_out_x <= '0;
                r_out_y <= '0;
            end
        end
        if (i_cmd.score_start) begin
            r_dx     <= (COORD_W+1)'(r_px) - (COORD_W+1)'(r_cx[r_idx]);
            r_dy     <= (COORD_W+1)'(r_py) - (COORD_W+1)'(r_cy[r_idx]);
            r_sq_cnt <= '0;
        end
        if (i_cmd.sqrt_step) begin
            if (r_sq_cnt == '0) begin
                r_sq_cnt <= r_sq_cnt + 1'b1;
            end else if (r_sq_cnt != SS_W'(SQ_STEPS)) begin
                r_sq_cnt <= r_sq_cnt + 1'b1;
            end
        end
        if (i_cmd.compare) begin
            if (r_idx == '0 || score < r_best) begin
                r_best <= score;
                r_win  <= r_idx;
            end
            if (!o_status.last_slot) begin
                r_idx <= r_idx + 1'b1;
            end else begin
                r_idx <= '0;
            end
        end
        if (i_cmd.sens_step) begin
            if (!o_status.last_slot) begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (i_cmd.div_start) begin
            r_upd      <= r_cnt[r_win] < COUNT_CAP;
            r_div_cnt  <= cnt_next[CNT_W-1:0];
            r_negx     <= sx_new[SUM_W-1];
            r_negy     <= sy_new[SUM_W-1];
            // Rounded division: numerator grows by half the divisor.
            r_qx       <= ax + SUM_W'(cnt_next[CNT_W:1]);
            r_qy       <= ay + SUM_W'(cnt_next[CNT_W:1]);
            r_rx       <= '0;
            r_ry       <= '0;
            r_div_step <= '0;
        end
        if (i_cmd.div_step && r_upd && r_div_step != DS_W'(DIV_STEPS)) begin
            r_div_step <= r_div_step + 1'b1;
            if (rx_t >= (SUM_W+1)'(r_div_cnt)) begin
                r_rx <= rx_t - (SUM_W+1)'(r_div_cnt);
                r_qx <= {r_qx[SUM_W-2:0], 1'b1};
            end else begin
                r_rx <= rx_t;
                r_qx <= {r_qx[SUM_W-2:0], 1'b0};
            end
            if (ry_t >= (SUM_W+1)'(r_div_cnt)) begin
                r_ry <= ry_t - (SUM_W+1)'(r_div_cnt);
                r_qy <= {r_qy[SUM_W-2:0], 1'b1};
            end else begin
                r_ry <= ry_t;
                r_qy <= {r_qy[SUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.finish) begin
            r_out_idx <= SLOT_W'(r_win);
            r_out_cnt <= r_cnt[r_win];
            r_out_x   <= r_upd ? COORD_W'(qx_s) : r_cx[r_win];
            r_out_y   <= r_upd ? COORD_W'(qy_s) : r_cy[r_win];
        end
    end

    // Digit-by-digit root: the first step loads the square and clears the
    // root, then two remainder bits enter per step.
    logic [SQ_W-1:0] r_sqv;
    logic [SQ_W+1:0] r_acc;
    logic [SQ_W+1:0] acc_t;
    logic [SQ_W+1:0] trial_t;
    assign acc_t   = {r_acc[SQ_W-1:0], r_sqv[SQ_W-1:SQ_W-2]};
    assign trial_t = (SQ_W+2)'({r_root, 2'b01});
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_step) begin
            if (r_sq_cnt == '0) begin
                r_sqv  <= sq;
                r_acc  <= '0;
                r_root <= '0;
            end else begin
                r_sqv <= {r_sqv[SQ_W-3:0], 2'b00};
                if (acc_t >= trial_t) begin
                    r_acc  <= acc_t - trial_t;
                    r_root <= {r_root[RT_W-2:0], 1'b1};
                end else begin
                    r_acc  <= acc_t;
                    r_root <= {r_root[RT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_winner_index = r_out_idx;
    assign o_center_x     = r_out_x;
    assign o_center_y     = r_out_y;
    assign o_member_count = r_out_cnt;

`ifndef SYNTHESIS
    a_sens_winner_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sens_step && r_idx == r_win) |=> (r_sens[$past(r_win)] == '0))
        else $error("winner sensitivity not cleared");
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= COUNT_CAP))
        else $error("member count above cap");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.compare |-> (NC_W'(r_idx) < r_n))
        else $error("scored an inactive slot");
`endif

endmodule

/* hw/rtl/sensitive_winner_centroid_update.sv */
// ----------------------------------------------------------------------------
// sensitive_winner_centroid_update
// Frequency-sensitive competitive learning over 2-D Q2.14 points.
// ----------------------------------------------------------------------------
// One item is handled at a time. A load item writes its slot and then presents
// its result. For a point item each active centroid's distance comes from a
// shared digit-by-digit square root unit, the sensitivities are then updated
// one slot a cycle, and the new mean comes from a restoring divider that
// produces one quotient bit a cycle for both coordinates at once. When the
// winner already holds its full member count the division is skipped. Every
// item yields exactly one result transfer; the result register holds it until
// it is taken.
module sensitive_winner_centroid_update
    import swcu_pkg::*;
#(
    parameter int unsigned MAX_CENTROIDS = 16,
    parameter int unsigned MAX_POINTS    = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // coord_x[15:0], coord_y[31:16]
    input  logic [4:0]  s_axis_tuser,  // operation[0], centroid_index[4:1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // winner_index, center_x, center_y, member_count
);

    t_cmd    cmd;
    t_status status;
    logic [SLOT_W-1:0]         win_idx;
    logic signed [COORD_W-1:0] cen_x, cen_y;
    logic [CNT_W-1:0]          mem_cnt;

    swcu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    swcu_dp #(
        .MAX_CENTROIDS (MAX_CENTROIDS),
        .MAX_POINTS    (MAX_POINTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_operation      (s_axis_tuser[0]),
        .i_centroid_index (s_axis_tuser[4:1]),
        .i_coord_x        (s_axis_tdata[15:0]),
        .i_coord_y        (s_axis_tdata[31:16]),
        .o_winner_index   (win_idx),
        .o_center_x       (cen_x),
        .o_center_y       (cen_y),
        .o_member_count   (mem_cnt)
    );

    // Fields from the lowest bit up, zero filled to whole bytes.
    assign m_axis_tdata = {1'b0, mem_cnt, cen_y, cen_x, win_idx};

endmodule
